[hw/rtl/sac_pkg.sv]
// ============================================================================
// sac_pkg - shared types and constants of the set-associative cache controller
// Beat payload structs, access codes, parameter defaults and the small
// control struct passed from the controller to the set store.
// ============================================================================
`default_nettype none

package sac_pkg;

    // Parameter defaults
    localparam int DEF_NUM_SETS     = 16;
    localparam int DEF_NUM_WAYS     = 4;
    localparam int DEF_BLOCK_BYTES  = 32;
    localparam int DEF_ADDRESS_BITS = 32;

    // Fixed beat field widths
    localparam int ADDR_FIELD_W = 32;
    localparam int BLK_FIELD_W  = 27;
    localparam int WAY_FIELD_W  = 2;
    localparam int CNT_W        = 32;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_STORE = 1'b1
    } sac_op_t;

    typedef struct packed {
        sac_op_t                 operation;
        logic [ADDR_FIELD_W-1:0] address;
    } sac_req_t;

    typedef struct packed {
        logic                   hit;
        logic [WAY_FIELD_W-1:0] way_used;
        logic                   victim_writeback;
        logic [BLK_FIELD_W-1:0] victim_block_address;
        logic [BLK_FIELD_W-1:0] fill_block_address;
        logic [CNT_W-1:0]       read_query_count;
        logic [CNT_W-1:0]       read_miss_count;
        logic [CNT_W-1:0]       write_query_count;
        logic [CNT_W-1:0]       write_miss_count;
    } sac_rsp_t;

    // Write control from the controller to the set store
    typedef struct packed {
        logic valid;   // an access is resolved this cycle
        logic fill;    // miss: install the new tag
    } sac_upd_t;

endpackage

`default_nettype wire

[hw/rtl/set_assoc_cache_controller.sv]
// ============================================================================
// set_assoc_cache_controller - tag/state/LRU controller of a write-back cache
// Set-associative, write-allocate lookup with LRU replacement, dirty-victim
// reporting and four wrapping access/miss counters.
// ============================================================================
//
//  channel   handshake            payload    beat accepted when
//  -------   ------------------   --------   ---------------------------
//  access    start / busy         req        start high, busy low
//  result    done (strobe)        rsp        done high (one cycle only)
//
//  One access per cycle; the result beat comes from the stage-two result register.
//  Stage one holds the access in the input register; stage two compares the
//  ways of its set, updates the set row and counters, and loads the result
//  register. The set row is written at the same edge that moves the next
//  access into stage two, so back-to-back accesses to one set see fresh state.
//  Reset clears valid, dirty and age bits of every set and the counters at
//  once; tags are not reset. busy stays low and the receiver cannot stall.
//  NUM_SETS and BLOCK_BYTES must be powers of two; the block does not check this.
//
`default_nettype none

module set_assoc_cache_controller
    import sac_pkg::*;
#(
    parameter int NUM_SETS     = DEF_NUM_SETS,
    parameter int NUM_WAYS     = DEF_NUM_WAYS,
    parameter int BLOCK_BYTES  = DEF_BLOCK_BYTES,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire sac_req_t req,
    output logic          done,
    output sac_rsp_t      rsp
);

    // Address split
    localparam int OFFSET_W = $clog2(BLOCK_BYTES);
    localparam int ADDR_W   = (ADDRESS_BITS < ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;
    localparam int BLK_W    = ADDR_W - OFFSET_W;
    localparam int SET_BITS = $clog2(NUM_SETS);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W    = BLK_W - SET_BITS;
    localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_W    = $clog2(NUM_WAYS + 1);

    // Stage one: input register
    sac_req_t req_reg;
    logic     req_vld_reg;

    // Stage two: result register and counters
    sac_rsp_t         rsp_reg;
    sac_rsp_t         rsp_next;
    logic             done_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic [CNT_W-1:0] rd_cnt_next;
    logic [CNT_W-1:0] rd_miss_reg;
    logic [CNT_W-1:0] rd_miss_next;
    logic [CNT_W-1:0] wr_cnt_reg;
    logic [CNT_W-1:0] wr_cnt_next;
    logic [CNT_W-1:0] wr_miss_reg;
    logic [CNT_W-1:0] wr_miss_next;

    logic [ADDR_W-1:0] addr_eff;
    logic [BLK_W-1:0]  block;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    logic              is_store;
    logic [BLK_W-1:0]  victim_blk;

    // Set row and lookup results
    logic [NUM_WAYS-1:0]            valid_row;
    logic [NUM_WAYS-1:0]            dirty_row;
    logic [NUM_WAYS-1:0][AGE_W-1:0] age_row;
    logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row;
    logic                           hit;
    logic [WAY_W-1:0]               way;
    logic                           victim_valid;
    logic                           victim_dirty;
    logic [TAG_W-1:0]               victim_tag;
    logic [NUM_WAYS-1:0]            valid_next;
    logic [NUM_WAYS-1:0]            dirty_next;
    logic [NUM_WAYS-1:0][AGE_W-1:0] age_next;
    sac_upd_t                       upd;

    // Accept every cycle: the pipeline never stalls
    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_vld_reg <= 1'b0;
        else
            req_vld_reg <= start && !busy;
    end

    // Hold the payload only on an accepted beat
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req;
    end

    // Split the byte address into block, set and tag
    assign addr_eff = req_reg.address[ADDR_W-1:0];
    assign block    = addr_eff[ADDR_W-1:OFFSET_W];
    assign set_idx  = (NUM_SETS > 1) ? block[SET_W-1:0] : '0;
    assign tag      = TAG_W'(block >> SET_BITS);
    assign is_store = (req_reg.operation == OP_STORE);

    assign upd.valid = req_vld_reg;
    assign upd.fill  = !hit;

    sac_set_store #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W),
        .AGE_W    (AGE_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_idx    (set_idx),
        .valid_row  (valid_row),
        .dirty_row  (dirty_row),
        .age_row    (age_row),
        .tag_row    (tag_row),
        .upd        (upd),
        .fill_way   (way),
        .tag_next   (tag),
        .valid_next (valid_next),
        .dirty_next (dirty_next),
        .age_next   (age_next)
    );

    sac_lookup #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W),
        .AGE_W    (AGE_W)
    ) u_lookup (
        .is_store     (is_store),
        .tag          (tag),
        .valid_row    (valid_row),
        .dirty_row    (dirty_row),
        .age_row      (age_row),
        .tag_row      (tag_row),
        .hit          (hit),
        .way          (way),
        .victim_valid (victim_valid),
        .victim_dirty (victim_dirty),
        .victim_tag   (victim_tag),
        .valid_next   (valid_next),
        .dirty_next   (dirty_next),
        .age_next     (age_next)
    );

    // Rebuild the victim block address from its tag and this set
    assign victim_blk = (BLK_W'(victim_tag) << SET_BITS) | BLK_W'(set_idx);

    // Advance the counters; the result carries the values after this access
    always_comb
    begin
        rd_cnt_next  = rd_cnt_reg;
        rd_miss_next = rd_miss_reg;
        wr_cnt_next  = wr_cnt_reg;
        wr_miss_next = wr_miss_reg;
        if (req_vld_reg)
        begin
            if (is_store)
            begin
                wr_cnt_next = wr_cnt_reg + CNT_W'(1);
                if (!hit)
                    wr_miss_next = wr_miss_reg + CNT_W'(1);
            end
            else
            begin
                rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                if (!hit)
                    rd_miss_next = rd_miss_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        rsp_next.hit                  = hit;
        rsp_next.way_used             = WAY_FIELD_W'(way);
        rsp_next.victim_writeback     = victim_dirty;
        rsp_next.victim_block_address = victim_valid ? BLK_FIELD_W'(victim_blk) : '0;
        rsp_next.fill_block_address   = hit ? '0 : BLK_FIELD_W'(block);
        rsp_next.read_query_count     = rd_cnt_next;
        rsp_next.read_miss_count      = rd_miss_next;
        rsp_next.write_query_count    = wr_cnt_next;
        rsp_next.write_miss_count     = wr_miss_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            rd_cnt_reg  <= '0;
            rd_miss_reg <= '0;
            wr_cnt_reg  <= '0;
            wr_miss_reg <= '0;
        end
        else
        begin
            done_reg    <= req_vld_reg;
            rd_cnt_reg  <= rd_cnt_next;
            rd_miss_reg <= rd_miss_next;
            wr_cnt_reg  <= wr_cnt_next;
            wr_miss_reg <= wr_miss_next;
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (req_vld_reg)
            rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

[hw/rtl/sac_set_store.sv]
// ============================================================================
// sac_set_store - per-set valid, dirty, age and tag registers
// Read the row of the addressed set; write back the updated row and,
// on a fill, the new tag of the chosen way.
// ============================================================================
`default_nettype none

module sac_set_store
    import sac_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    parameter int TAG_W    = 23,
    parameter int AGE_W    = 3,
    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [SET_W-1:0]                 set_idx,
    output logic      [NUM_WAYS-1:0]              valid_row,
    output logic      [NUM_WAYS-1:0]              dirty_row,
    output logic      [NUM_WAYS-1:0][AGE_W-1:0]   age_row,
    output logic      [NUM_WAYS-1:0][TAG_W-1:0]   tag_row,
    input  wire sac_upd_t                         upd,
    input  wire logic [WAY_W-1:0]                 fill_way,
    input  wire logic [TAG_W-1:0]                 tag_next,
    input  wire logic [NUM_WAYS-1:0]              valid_next,
    input  wire logic [NUM_WAYS-1:0]              dirty_next,
    input  wire logic [NUM_WAYS-1:0][AGE_W-1:0]   age_next
);

    logic [NUM_WAYS-1:0]            valid_reg [NUM_SETS];
    logic [NUM_WAYS-1:0]            dirty_reg [NUM_SETS];
    logic [NUM_WAYS-1:0][AGE_W-1:0] age_reg   [NUM_SETS];
    logic [NUM_WAYS-1:0][TAG_W-1:0] tag_reg   [NUM_SETS];

    assign valid_row = valid_reg[set_idx];
    assign dirty_row = dirty_reg[set_idx];
    assign age_row   = age_reg[set_idx];
    assign tag_row   = tag_reg[set_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                valid_reg[s] <= '0;
                dirty_reg[s] <= '0;
                age_reg[s]   <= '0;
            end
        end
        else if (upd.valid)
        begin
            valid_reg[set_idx] <= valid_next;
            dirty_reg[set_idx] <= dirty_next;
            age_reg[set_idx]   <= age_next;
        end
    end

    // Tags hold no reset: a way is read only once its valid bit is set
    always_ff @(posedge clk)
    begin
        if (upd.valid && upd.fill)
        begin
            tag_reg[set_idx][fill_way] <= tag_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sac_lookup.sv]
// ============================================================================
// sac_lookup - tag compare, victim choice and LRU age update for one set
// Compare all ways at once, pick the first unused or oldest way on a miss,
// and form the next valid, dirty and age values of the row.
// ============================================================================
`default_nettype none

module sac_lookup
    import sac_pkg::*;
#(
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    parameter int TAG_W    = 23,
    parameter int AGE_W    = 3,
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
)
(
    input  wire logic                             is_store,
    input  wire logic [TAG_W-1:0]                 tag,
    input  wire logic [NUM_WAYS-1:0]              valid_row,
    input  wire logic [NUM_WAYS-1:0]              dirty_row,
    input  wire logic [NUM_WAYS-1:0][AGE_W-1:0]   age_row,
    input  wire logic [NUM_WAYS-1:0][TAG_W-1:0]   tag_row,
    output logic                                  hit,
    output logic      [WAY_W-1:0]                 way,
    output logic                                  victim_valid,
    output logic                                  victim_dirty,
    output logic      [TAG_W-1:0]                 victim_tag,
    output logic      [NUM_WAYS-1:0]              valid_next,
    output logic      [NUM_WAYS-1:0]              dirty_next,
    output logic      [NUM_WAYS-1:0][AGE_W-1:0]   age_next
);

    logic [WAY_W-1:0] hit_way;
    logic             free_found;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] old_way;
    logic [AGE_W-1:0] old_age;
    logic [AGE_W-1:0] ref_age;
    logic             fresh;

    always_comb
    begin
        // Tag compare over all ways
        hit     = 1'b0;
        hit_way = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (valid_row[i] && (tag_row[i] == tag))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
        end

        // First never-used way
        free_found = 1'b0;
        free_way   = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (age_row[i] == '0)
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(i);
            end
        end

        // Oldest way, lowest index on a tie
        old_way = '0;
        old_age = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (age_row[i] > old_age)
            begin
                old_age = age_row[i];
                old_way = WAY_W'(i);
            end
        end

        if (hit)
            way = hit_way;
        else if (free_found)
            way = free_way;
        else
            way = old_way;

        ref_age = age_row[way];
        fresh   = (ref_age == '0);

        // Age the others, make the touched way the most recent
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            age_next[i] = age_row[i];
            if (WAY_W'(i) == way)
                age_next[i] = AGE_W'(1);
            else if (hit)
            begin
                if ((age_row[i] != '0) && (age_row[i] < ref_age))
                    age_next[i] = age_row[i] + AGE_W'(1);
            end
            else if (!fresh || (age_row[i] != '0))
                age_next[i] = age_row[i] + AGE_W'(1);
        end

        valid_next      = valid_row;
        valid_next[way] = 1'b1;

        dirty_next = dirty_row;
        if (hit)
        begin
            if (is_store)
                dirty_next[way] = 1'b1;
        end
        else
            dirty_next[way] = is_store;

        victim_valid = !hit && valid_row[way];
        victim_dirty = victim_valid && dirty_row[way];
        victim_tag   = tag_row[way];
    end

endmodule

`default_nettype wire
